/* rtl/core/mvm_pkg.sv */
`default_nettype none
package mvm_pkg;

  // Field widths.
  localparam int VALUE_W = 16;
  localparam int PROD_W  = 32;
  localparam int SUM_W   = 40;
  localparam int COL_W   = 8;
  localparam int ROW_W   = 8;
  localparam int SIZE_W  = 9;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request kinds.
  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_MATRIX = 1'b1
  } req_kind_t;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } reg_index_t;

  // Effective sizes, already clamped to their legal ranges.
  typedef struct packed {
    logic [SIZE_W-1:0] cols;
    logic [SIZE_W-1:0] rows;
  } sizes_t;

  // One matrix element with its vector operand, ready to multiply.
  typedef struct packed {
    logic signed [VALUE_W-1:0] mat_value;
    logic signed [VALUE_W-1:0] vec_value;
    logic                      last_col;
  } mac_op_t;

endpackage
`default_nettype wire

/* rtl/core/mvm_in_if.sv */
`default_nettype none
interface mvm_in_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic [mvm_pkg::COL_W-1:0]          col_index;
  logic signed [mvm_pkg::VALUE_W-1:0] value;

  modport source (output valid, output req_type, output col_index, output value,
                  input ready);
  modport sink   (input valid, input req_type, input col_index, input value,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/mvm_out_if.sv */
`default_nettype none
interface mvm_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [mvm_pkg::SUM_W-1:0] row_sum;
  logic [mvm_pkg::ROW_W-1:0]        row_index;
  logic                             last_row;

  modport source (output valid, output row_sum, output row_index, output last_row,
                  input ready);
  modport sink   (input valid, input row_sum, input row_index, input last_row,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/mvm_front.sv */
`default_nettype none
module mvm_front #(
  parameter int STORE_DEPTH = 256
) (
  input  wire logic            clk,
  input  wire logic            rst,
  mvm_in_if.sink               item,
  input  wire mvm_pkg::sizes_t sizes,
  output mvm_pkg::mac_op_t     push_op,
  output logic                 push,
  input  wire logic            q_full
);
  import mvm_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic signed [VALUE_W-1:0] store [STORE_DEPTH];
  logic                      s1_valid;
  logic signed [VALUE_W-1:0] s1_mat;
  logic signed [VALUE_W-1:0] s1_vec;
  logic                      s1_last;
  logic                      accept;
  logic                      take_load;
  logic                      take_mat;
  logic [SIZE_W-1:0]         col_ext;
  logic [AW-1:0]             addr;

  // Classify the request: in-range loads go to the store, in-range matrix
  // elements fetch their vector operand; everything else is dropped.
  assign item.ready = !s1_valid || !q_full;
  assign accept     = item.valid && item.ready;
  assign col_ext    = {1'b0, item.col_index};
  assign addr       = item.col_index[AW-1:0];
  assign take_load  = accept && (item.req_type == REQ_LOAD)
                      && (col_ext < SIZE_W'(STORE_DEPTH));
  assign take_mat   = accept && (item.req_type == REQ_MATRIX)
                      && (col_ext < sizes.cols);

  // Vector store with a registered read port.
  always_ff @(posedge clk) begin
    if (take_load) begin
      store[addr] <= item.value;
    end
    if (take_mat) begin
      s1_vec  <= store[addr];
      s1_mat  <= item.value;
      s1_last <= (col_ext == (sizes.cols - SIZE_W'(1)));
    end
  end

  // Holding stage in front of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take_mat) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  assign push              = s1_valid && !q_full;
  assign push_op.mat_value = s1_mat;
  assign push_op.vec_value = s1_vec;
  assign push_op.last_col  = s1_last;

endmodule
`default_nettype wire

/* rtl/core/mvm_queue.sv */
`default_nettype none
module mvm_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire mvm_pkg::mac_op_t push_op,
  output logic                  full,
  input  wire logic             pop,
  output mvm_pkg::mac_op_t      pop_op,
  output logic                  not_empty
);
  import mvm_pkg::*;

  mac_op_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_op    = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mvm_back.sv */
`default_nettype none
module mvm_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             restart,
  input  wire mvm_pkg::sizes_t  sizes,
  input  wire mvm_pkg::mac_op_t pop_op,
  input  wire logic             not_empty,
  output logic                  pop,
  mvm_out_if.source             result
);
  import mvm_pkg::*;

  logic                     m_valid;
  logic signed [PROD_W-1:0] m_prod;
  logic                     m_last;
  logic signed [SUM_W-1:0]  running_sum;
  logic signed [SUM_W-1:0]  sum_next;
  logic [ROW_W-1:0]         current_row;
  logic                     row_is_last;
  logic                     out_valid;
  logic                     out_free;
  logic                     acc_take;
  logic                     emit;

  // Output slot is free when empty or being taken this cycle.
  assign out_free    = !out_valid || result.ready;
  assign acc_take    = m_valid && (!m_last || out_free);
  assign emit        = acc_take && m_last;
  assign pop         = not_empty && (!m_valid || acc_take);
  assign sum_next    = running_sum + SUM_W'(m_prod);
  assign row_is_last = ({1'b0, current_row} >= (sizes.rows - SIZE_W'(1)));

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (pop) begin
      m_prod <= pop_op.mat_value * pop_op.vec_value;
      m_last <= pop_op.last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (pop) begin
      m_valid <= 1'b1;
    end else if (acc_take) begin
      m_valid <= 1'b0;
    end
  end

  // Accumulate stage; the last column closes the row.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      running_sum <= '0;
      current_row <= '0;
    end else if (acc_take) begin
      if (m_last) begin
        running_sum <= '0;
        current_row <= row_is_last ? '0 : current_row + ROW_W'(1);
      end else begin
        running_sum <= sum_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (emit) begin
      result.row_sum   <= sum_next;
      result.row_index <= current_row;
      result.last_row  <= row_is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid = out_valid;

endmodule
`default_nettype wire

/* rtl/core/matrix_vector_multiply_top.sv */
// Path of an element: holding stage, queue, multiply register, then the result register.
// Throughput: one request per cycle while result.ready is high, set by the single back-end MAC.
// A four-entry queue decouples request intake from the accumulator and the result register.
// Reset (synchronous, active high) clears the sum, row count and handshakes; sizes go to 256.
// The vector store is not cleared and holds undefined data until written.
`default_nettype none
module matrix_vector_multiply_top #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  mvm_in_if.sink           item,
  mvm_out_if.source        result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mvm_pkg::*;

  localparam int COL_CAP = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int ROW_CAP = (MAX_ROWS < 256) ? MAX_ROWS : 256;

  logic [SIZE_W-1:0] num_rows;
  logic [SIZE_W-1:0] num_cols;
  logic              cfg_write;
  reg_index_t        reg_sel;
  sizes_t            sizes;
  mac_op_t           push_op;
  mac_op_t           pop_op;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_not_empty;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= SIZE_W'(256);
      num_cols <= SIZE_W'(256);
    end else if (cfg_write) begin
      case (reg_sel)
        REG_NUM_ROWS: num_rows <= pwdata[SIZE_W-1:0];
        REG_NUM_COLS: num_cols <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_NUM_ROWS: prdata = {{(32 - SIZE_W){1'b0}}, num_rows};
      REG_NUM_COLS: prdata = {{(32 - SIZE_W){1'b0}}, num_cols};
      default:      prdata = '0;
    endcase
  end

  // Clamp the sizes: zero counts as one, and the caps bound them above.
  always_comb begin
    if (num_cols == '0) begin
      sizes.cols = SIZE_W'(1);
    end else if (num_cols > SIZE_W'(COL_CAP)) begin
      sizes.cols = SIZE_W'(COL_CAP);
    end else begin
      sizes.cols = num_cols;
    end
    if (num_rows == '0) begin
      sizes.rows = SIZE_W'(1);
    end else if (num_rows > SIZE_W'(ROW_CAP)) begin
      sizes.rows = SIZE_W'(ROW_CAP);
    end else begin
      sizes.rows = num_rows;
    end
  end

  mvm_front #(
    .STORE_DEPTH (COL_CAP)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .sizes   (sizes),
    .push_op (push_op),
    .push    (push),
    .q_full  (q_full)
  );

  mvm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (pop),
    .pop_op    (pop_op),
    .not_empty (q_not_empty)
  );

  mvm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .restart   (cfg_write),
    .sizes     (sizes),
    .pop_op    (pop_op),
    .not_empty (q_not_empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
`default_nettype wire
